>>> src/masked_a2b_table_conversion_defines.svh
// Assertion macros for the arithmetic-to-Boolean conversion block.
`ifndef MASKED_A2B_TABLE_CONVERSION_DEFINES_SVH
`define MASKED_A2B_TABLE_CONVERSION_DEFINES_SVH

`ifndef SYNTHESIS

`define MA2B_ASSERT(label, ck, rn, expr) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (expr)) \
    else $error("ma2b assertion failed");

`define MA2B_ASSERT_IMPLY(label, ck, rn, pre, post) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (pre) |-> (post)) \
    else $error("ma2b implication failed");

`else

`define MA2B_ASSERT(label, ck, rn, expr)

`define MA2B_ASSERT_IMPLY(label, ck, rn, pre, post)

`endif

`endif

>>> src/ma2b_pkg.sv
package ma2b_pkg;

  localparam int WORD_W      = 32;
  localparam int IN_MASK_W   = 4;
  localparam int MAX_CHUNK_W = 8;
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = 1;

  typedef logic [WORD_W-1:0]      word_t;
  typedef logic [MAX_CHUNK_W-1:0] cmask_t;

  typedef struct packed {
    word_t  a;
    word_t  rmask;
    cmask_t r;
    logic   rho;
    word_t  gamma;
  } item_t;

  typedef struct packed {
    item_t item;
    word_t b;
  } stage_t;

  typedef struct packed {
    logic can_push;
    logic head_vld;
  } q_stat_t;

  function automatic word_t full_mask(input int total);
    word_t m;
    if (total >= WORD_W) begin
      m = '1;
    end else begin
      m = (word_t'(1) << total) - word_t'(1);
    end
    return m;
  endfunction

  function automatic word_t replicate(input cmask_t v, input int cw, input int n);
    word_t acc;
    acc = '0;
    for (int i = 0; i < WORD_W; i++) begin
      for (int j = 0; j < MAX_CHUNK_W; j++) begin
        if (j < cw && i < n && (i * cw + j) < WORD_W) begin
          acc[i*cw+j] = v[j];
        end
      end
    end
    return acc;
  endfunction

endpackage

>>> src/ma2b_front.sv
module ma2b_front #(
  parameter int CHUNK_BITS = 4,
  parameter int CHUNKS     = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [31:0]                  in_arith_share,
  input  logic [31:0]                  in_arith_mask,
  input  logic [3:0]                   in_chunk_mask,
  input  logic                         in_carry_mask_bit,
  input  logic [31:0]                  in_gamma_word,
  input  ma2b_pkg::q_stat_t            q_stat,
  output logic                         push,
  output ma2b_pkg::item_t              push_item
);

  localparam int TOTAL = CHUNK_BITS * CHUNKS;
  localparam ma2b_pkg::word_t FULL = ma2b_pkg::full_mask(TOTAL);
  localparam ma2b_pkg::word_t GAMMA_K =
    (ma2b_pkg::replicate(ma2b_pkg::cmask_t'(1), CHUNK_BITS, CHUNKS) -
     ma2b_pkg::word_t'(1)) & FULL;
  localparam ma2b_pkg::cmask_t R_MASK =
    ma2b_pkg::cmask_t'((9'd1 << CHUNK_BITS) - 9'd1);

  logic                   accept;
  logic                   f_vld_r;
  logic                   f_vld_nxt;
  ma2b_pkg::word_t        a_m;
  ma2b_pkg::word_t        g_m;
  ma2b_pkg::cmask_t       r_cut;
  ma2b_pkg::word_t        rrr;
  ma2b_pkg::word_t        prod;
  ma2b_pkg::word_t        f_diff_r;
  ma2b_pkg::word_t        f_bg_r;
  ma2b_pkg::word_t        f_rmask_r;
  ma2b_pkg::cmask_t       f_r_r;
  logic                   f_rho_r;
  ma2b_pkg::word_t        f_gamma_r;

  assign busy   = ~rst_n | (f_vld_r & ~q_stat.can_push);
  assign accept = start & ~busy;
  assign push   = f_vld_r & q_stat.can_push;

  always_comb begin
    a_m   = in_arith_share & FULL;
    g_m   = in_gamma_word & FULL;
    r_cut = {{(ma2b_pkg::MAX_CHUNK_W-ma2b_pkg::IN_MASK_W){1'b0}}, in_chunk_mask} & R_MASK;
    rrr   = ma2b_pkg::replicate(r_cut, CHUNK_BITS, CHUNKS) & FULL;
    prod  = g_m * GAMMA_K;
  end

  always_comb begin
    f_vld_nxt = accept | (f_vld_r & ~push);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= f_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_diff_r  <= (a_m - rrr) & FULL;
      f_bg_r    <= prod & FULL;
      f_rmask_r <= in_arith_mask & FULL;
      f_r_r     <= r_cut;
      f_rho_r   <= in_carry_mask_bit;
      f_gamma_r <= g_m;
    end
  end

  always_comb begin
    push_item.a     = (f_diff_r - f_bg_r) & FULL;
    push_item.rmask = f_rmask_r;
    push_item.r     = f_r_r;
    push_item.rho   = f_rho_r;
    push_item.gamma = f_gamma_r;
  end

endmodule

>>> src/ma2b_queue.sv
module ma2b_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ma2b_pkg::item_t   push_item,
  output ma2b_pkg::q_stat_t q_stat,
  output ma2b_pkg::item_t   head_item
);

  ma2b_pkg::item_t            mem_r [ma2b_pkg::Q_DEPTH];
  logic [ma2b_pkg::Q_PTR_W-1:0] wr_ptr_r;
  logic [ma2b_pkg::Q_PTR_W-1:0] rd_ptr_r;
  logic [ma2b_pkg::Q_PTR_W:0]   cnt_r;
  logic [ma2b_pkg::Q_PTR_W:0]   cnt_nxt;
  logic                         full;
  logic                         empty;
  logic                         pop;
  logic                         wr;

  assign full  = (cnt_r == (ma2b_pkg::Q_PTR_W+1)'(ma2b_pkg::Q_DEPTH));
  assign empty = (cnt_r == '0);
  // back end takes the head every cycle it is there
  assign pop   = ~empty;
  assign wr    = push & (~full | pop);

  assign q_stat.can_push = ~full | pop;
  assign q_stat.head_vld = ~empty;
  assign head_item       = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!wr && pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> src/ma2b_chunk_pipe.sv
module ma2b_chunk_pipe #(
  parameter int CHUNK_BITS = 4,
  parameter int CHUNKS     = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ma2b_pkg::q_stat_t q_stat,
  input  ma2b_pkg::item_t   head_item,
  output logic              out_strobe,
  output logic [31:0]       out_bool_share
);

  localparam int TOTAL = CHUNK_BITS * CHUNKS;
  localparam ma2b_pkg::word_t FULL = ma2b_pkg::full_mask(TOTAL);

  ma2b_pkg::stage_t stg_in   [CHUNKS];
  ma2b_pkg::stage_t stg_nxt  [CHUNKS];
  ma2b_pkg::stage_t pipe_r   [CHUNKS];
  logic             vld_r    [CHUNKS];
  logic             out_strobe_r;
  ma2b_pkg::word_t  out_share_r;
  ma2b_pkg::word_t  rrr_last;

  for (genvar i = 0; i < CHUNKS; i++) begin : g_chunk
    logic [CHUNK_BITS-1:0] rl;
    logic [CHUNK_BITS-1:0] rr;
    logic [CHUNK_BITS-1:0] al;
    logic [CHUNK_BITS-1:0] bi;
    logic [CHUNK_BITS:0]   low;
    logic [CHUNK_BITS:0]   look;
    logic                  beta;
    logic [1:0]            inc;

    if (i == 0) begin : g_head
      assign stg_in[i] = {head_item, {ma2b_pkg::WORD_W{1'b0}}};
    end else begin : g_link
      assign stg_in[i] = pipe_r[i-1];
    end

    always_comb begin
      rl   = stg_in[i].item.rmask[CHUNK_BITS-1:0];
      rr   = stg_in[i].item.r[CHUNK_BITS-1:0];
      low  = {1'b0, stg_in[i].item.a[CHUNK_BITS-1:0]} + {1'b0, rl};
      al   = low[CHUNK_BITS-1:0];
      look = ({1'b0, al} + {1'b0, rr}) ^ {stg_in[i].item.rho, rr};
      beta = look[CHUNK_BITS];
      bi   = look[CHUNK_BITS-1:0] ^ rl;
      inc  = {1'b0, low[CHUNK_BITS]} + {1'b0, beta ^ stg_in[i].item.rho};

      stg_nxt[i] = stg_in[i];
      stg_nxt[i].item.a = (stg_in[i].item.a >> CHUNK_BITS) + stg_in[i].item.gamma +
                          {{(ma2b_pkg::WORD_W-2){1'b0}}, inc};
      stg_nxt[i].item.rmask = stg_in[i].item.rmask >> CHUNK_BITS;
      stg_nxt[i].b[i*CHUNK_BITS +: CHUNK_BITS] = bi;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (i == 0) begin
        vld_r[i] <= q_stat.head_vld;
      end else begin
        vld_r[i] <= vld_r[(i == 0) ? 0 : i-1];
      end
    end

    always_ff @(posedge clk) begin
      pipe_r[i] <= stg_nxt[i];
    end
  end

  assign rrr_last = ma2b_pkg::replicate(pipe_r[CHUNKS-1].item.r, CHUNK_BITS, CHUNKS) & FULL;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= vld_r[CHUNKS-1];
    end
  end

  always_ff @(posedge clk) begin
    out_share_r <= (pipe_r[CHUNKS-1].b ^ rrr_last) & FULL;
  end

  assign out_strobe     = out_strobe_r;
  assign out_bool_share = out_share_r;

endmodule

>>> src/masked_a2b_table_conversion.sv
// A request is registered in the front end at the edge that accepts it, then passes the queue
// write, one chunk stage per chunk and the output register before its result strobes.
// Throughput: one request per cycle; the chunk pipeline advances every cycle.
// busy stays low in operation since the receiver cannot stall the result strobe.
// Reset: synchronous, active low; clears valids and queue pointers, busy is high meanwhile.
`include "masked_a2b_table_conversion_defines.svh"

module masked_a2b_table_conversion #(
  parameter int CHUNK_BITS = 4,
  parameter int CHUNKS     = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_arith_share,
  input  logic [31:0] in_arith_mask,
  input  logic [3:0]  in_chunk_mask,
  input  logic        in_carry_mask_bit,
  input  logic [31:0] in_gamma_word,
  output logic        out_strobe,
  output logic [31:0] out_bool_share
);

  localparam ma2b_pkg::word_t FULL = ma2b_pkg::full_mask(CHUNK_BITS * CHUNKS);

  ma2b_pkg::q_stat_t q_stat;
  ma2b_pkg::item_t   push_item;
  ma2b_pkg::item_t   head_item;
  logic              q_push;

  ma2b_front #(
    .CHUNK_BITS(CHUNK_BITS),
    .CHUNKS    (CHUNKS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_arith_share   (in_arith_share),
    .in_arith_mask    (in_arith_mask),
    .in_chunk_mask    (in_chunk_mask),
    .in_carry_mask_bit(in_carry_mask_bit),
    .in_gamma_word    (in_gamma_word),
    .q_stat           (q_stat),
    .push             (q_push),
    .push_item        (push_item)
  );

  ma2b_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_item(push_item),
    .q_stat   (q_stat),
    .head_item(head_item)
  );

  ma2b_chunk_pipe #(
    .CHUNK_BITS(CHUNK_BITS),
    .CHUNKS    (CHUNKS)
  ) u_pipe (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_stat        (q_stat),
    .head_item     (head_item),
    .out_strobe    (out_strobe),
    .out_bool_share(out_bool_share)
  );

  `MA2B_ASSERT_IMPLY(a_push_has_room, clk, rst_n, q_push, q_stat.can_push)
  `MA2B_ASSERT(a_never_busy, clk, rst_n, !busy)
  `MA2B_ASSERT_IMPLY(a_high_bits_zero, clk, rst_n, out_strobe, (out_bool_share & ~FULL) == '0)

endmodule
